// File: hdl/ucdp_pkg.sv
// ----------------------------------------------------------------------------
// ucdp_pkg
// Shared types and constants for the configuration descriptor parser.
// ----------------------------------------------------------------------------
package ucdp_pkg;

    // descriptor type codes
    localparam logic [7:0] KIND_CONFIG    = 8'd2;
    localparam logic [7:0] KIND_INTERFACE = 8'd4;
    localparam logic [7:0] KIND_ENDPOINT  = 8'd5;

    // endpoint address fields
    localparam int         DIR_IN_BIT  = 7;
    localparam logic [7:0] EP_NUM_MASK = 8'h0F;

    // result record codes
    localparam logic REC_ENDPOINT = 1'b0;
    localparam logic REC_SUMMARY  = 1'b1;

    localparam int EVQ_DEPTH = 4;

    // one byte's worth of work for the back end
    typedef struct packed {
        logic        complete;
        logic [7:0]  kind;
        logic [7:0]  address;
        logic [7:0]  attributes;
        logic [15:0] size;
        logic        zero_len;
        logic        last;
        logic        trunc;
    } event_t;

    // one result record
    typedef struct packed {
        logic        record_type;
        logic [3:0]  interface_slot;
        logic        direction_in;
        logic [1:0]  endpoint_slot;
        logic [3:0]  endpoint_number;
        logic [15:0] max_packet_size;
        logic [7:0]  endpoint_attributes;
        logic [4:0]  interface_count;
        logic        malformed;
        logic        last_result;
    } result_t;

endpackage

// File: hdl/usb_config_descriptor_endpoint_parser.sv
// ----------------------------------------------------------------------------
// usb_config_descriptor_endpoint_parser
// Parses a configuration descriptor byte stream into endpoint records and
// an end-of-buffer summary.
// ----------------------------------------------------------------------------
//  channel   handshake     payload
//  bytes     push / full   data_byte, last_byte
//  records   pop / empty   record_type ... last_result
//
//  one byte per cycle while full is low; a final byte that also completes an
//  endpoint gives its record, then the summary, one per cycle given room.
//  the front end registers the descriptor framing; a four-entry event queue
//  separates it from the interface and endpoint bookkeeping.
//  full rises only when the event queue fills behind a stalled result side.
//  reset clears all parse state, both queues and the pending results.
// ----------------------------------------------------------------------------
module usb_config_descriptor_endpoint_parser
#(
    parameter int MAX_INTERFACES          = 4,
    parameter int ENDPOINTS_PER_DIRECTION = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic        record_type,
    output logic [3:0]  interface_slot,
    output logic        direction_in,
    output logic [1:0]  endpoint_slot,
    output logic [3:0]  endpoint_number,
    output logic [15:0] max_packet_size,
    output logic [7:0]  endpoint_attributes,
    output logic [4:0]  interface_count,
    output logic        malformed,
    output logic        last_result
);
    import ucdp_pkg::*;

    logic    take;
    logic    fe_valid;
    event_t  fe_evt;
    logic    q_valid;
    event_t  q_evt;
    logic    q_pop;
    result_t res;

    // byte transaction accepted
    assign take = push && !full;

    ucdp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .evt_valid (fe_valid),
        .evt       (fe_evt)
    );

    ucdp_evq u_evq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fe_valid),
        .wr_data  (fe_evt),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_evt)
    );

    ucdp_back
    #(
        .MAX_INTERFACES          (MAX_INTERFACES),
        .ENDPOINTS_PER_DIRECTION (ENDPOINTS_PER_DIRECTION)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (q_valid),
        .evt       (q_evt),
        .evt_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (res)
    );

    // result fields
    assign record_type         = res.record_type;
    assign interface_slot      = res.interface_slot;
    assign direction_in        = res.direction_in;
    assign endpoint_slot       = res.endpoint_slot;
    assign endpoint_number     = res.endpoint_number;
    assign max_packet_size     = res.max_packet_size;
    assign endpoint_attributes = res.endpoint_attributes;
    assign interface_count     = res.interface_count;
    assign malformed           = res.malformed;
    assign last_result         = res.last_result;

endmodule

// File: hdl/ucdp_front.sv
// ----------------------------------------------------------------------------
// ucdp_front
// Splits the byte stream into descriptors by their length bytes and hands
// each completed descriptor, zero length byte or buffer end to the back end.
// ----------------------------------------------------------------------------
module ucdp_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output logic             evt_valid,
    output ucdp_pkg::event_t evt
);
    import ucdp_pkg::*;

    logic [7:0]  offset_reg, offset_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  attr_reg, attr_next;
    logic [15:0] size_reg, size_next;
    logic        stopped_reg, stopped_next;
    logic        complete;
    logic        zero_len;

    // byte classification and capture
    always_comb
    begin
        offset_next  = offset_reg;
        length_next  = length_reg;
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        attr_next    = attr_reg;
        size_next    = size_reg;
        stopped_next = stopped_reg;
        complete     = 1'b0;
        zero_len     = 1'b0;
        if (!stopped_reg)
        begin
            unique case (offset_reg)
                8'd0:
                begin
                    if (data_byte == 8'd0)
                    begin
                        stopped_next = 1'b1;
                        zero_len     = 1'b1;
                    end
                    else
                    begin
                        length_next = data_byte;
                        kind_next   = 8'd0;
                        addr_next   = 8'd0;
                        attr_next   = 8'd0;
                        size_next   = 16'd0;
                    end
                end
                8'd1:    kind_next = data_byte;
                8'd2:    addr_next = data_byte;
                8'd3:    attr_next = data_byte;
                8'd4:    size_next = {size_reg[15:8], data_byte};
                8'd5:    size_next = {data_byte, size_reg[7:0]};
                default: ;
            endcase
            if (!stopped_next)
            begin
                if ({1'b0, offset_reg} + 9'd1 >= {1'b0, length_next})
                begin
                    offset_next = 8'd0;
                    complete    = 1'b1;
                end
                else
                begin
                    offset_next = offset_reg + 8'd1;
                end
            end
        end
    end

    // event toward the back end
    always_comb
    begin
        evt.complete   = complete;
        evt.kind       = kind_next;
        evt.address    = addr_next;
        evt.attributes = attr_next;
        evt.size       = size_next;
        evt.zero_len   = zero_len;
        evt.last       = last_byte;
        evt.trunc      = last_byte && !stopped_next && (offset_next != 8'd0);
        evt_valid      = take && (complete || zero_len || last_byte);
    end

    // parse state, cleared at buffer end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= 8'd0;
            length_reg  <= 8'd0;
            kind_reg    <= 8'd0;
            addr_reg    <= 8'd0;
            attr_reg    <= 8'd0;
            size_reg    <= 16'd0;
            stopped_reg <= 1'b0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                offset_reg  <= 8'd0;
                length_reg  <= 8'd0;
                kind_reg    <= 8'd0;
                addr_reg    <= 8'd0;
                attr_reg    <= 8'd0;
                size_reg    <= 16'd0;
                stopped_reg <= 1'b0;
            end
            else
            begin
                offset_reg  <= offset_next;
                length_reg  <= length_next;
                kind_reg    <= kind_next;
                addr_reg    <= addr_next;
                attr_reg    <= attr_next;
                size_reg    <= size_next;
                stopped_reg <= stopped_next;
            end
        end
    end

endmodule

// File: hdl/ucdp_evq.sv
// ----------------------------------------------------------------------------
// ucdp_evq
// Short event queue between the front and back ends.
// ----------------------------------------------------------------------------
module ucdp_evq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  ucdp_pkg::event_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic             rd_valid,
    output ucdp_pkg::event_t rd_data
);
    import ucdp_pkg::*;

    localparam int PtrW = $clog2(EVQ_DEPTH);

    event_t          mem [EVQ_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW:0]   count_reg;

    assign full     = (count_reg == (PtrW+1)'(EVQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            priority if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/ucdp_back.sv
// ----------------------------------------------------------------------------
// ucdp_back
// Tracks interfaces and endpoint slots, builds endpoint records and the
// buffer summary, and holds them in a two-entry result queue.
// ----------------------------------------------------------------------------
module ucdp_back
#(
    parameter int MAX_INTERFACES          = 4,
    parameter int ENDPOINTS_PER_DIRECTION = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              evt_valid,
    input  ucdp_pkg::event_t  evt,
    output logic              evt_pop,
    output logic              empty,
    input  logic              pop,
    output ucdp_pkg::result_t result
);
    import ucdp_pkg::*;

    localparam int IfW = $clog2(MAX_INTERFACES + 1);
    localparam int EpW = $clog2(ENDPOINTS_PER_DIRECTION + 1);

    logic [4:0]     declared_reg, declared_next;
    logic [IfW-1:0] opened_reg, opened_next;
    logic [EpW-1:0] in_used_reg, in_used_next;
    logic [EpW-1:0] out_used_reg, out_used_next;
    logic           inside_reg, inside_next;
    logic           stopped_reg, stopped_next;
    logic           malformed_reg, malformed_next;
    logic           phase_reg;

    result_t        oq [2];
    logic           oq_wr_reg;
    logic           oq_rd_reg;
    logic [1:0]     oq_count_reg;

    logic           act;
    logic           is_in;
    logic [EpW-1:0] used_cur;
    logic           rec;
    logic           room;
    logic           fire;
    logic           emit;
    logic           deq;
    result_t        res;

    assign act      = evt_valid && !stopped_reg && !phase_reg;
    assign is_in    = evt.address[DIR_IN_BIT];
    assign used_cur = is_in ? in_used_reg : out_used_reg;
    assign rec      = act && evt.complete && (evt.kind == KIND_ENDPOINT) && inside_reg
                      && (used_cur < EpW'(ENDPOINTS_PER_DIRECTION));

    // descriptor bookkeeping
    always_comb
    begin
        declared_next  = declared_reg;
        opened_next    = opened_reg;
        in_used_next   = in_used_reg;
        out_used_next  = out_used_reg;
        inside_next    = inside_reg;
        stopped_next   = stopped_reg;
        malformed_next = malformed_reg;
        if (act)
        begin
            if (evt.zero_len)
            begin
                stopped_next   = 1'b1;
                malformed_next = 1'b1;
            end
            if (evt.complete)
            begin
                priority if (evt.kind == KIND_CONFIG)
                begin
                    if (evt.size[7:0] > 8'(MAX_INTERFACES))
                    begin
                        declared_next = 5'(MAX_INTERFACES);
                    end
                    else
                    begin
                        declared_next = evt.size[4:0];
                    end
                    inside_next = 1'b0;
                end
                else if (evt.kind == KIND_INTERFACE)
                begin
                    if (opened_reg >= IfW'(MAX_INTERFACES))
                    begin
                        stopped_next = 1'b1;
                        inside_next  = 1'b0;
                    end
                    else
                    begin
                        opened_next   = opened_reg + 1'b1;
                        inside_next   = 1'b1;
                        in_used_next  = '0;
                        out_used_next = '0;
                    end
                end
                else if (rec)
                begin
                    if (is_in)
                    begin
                        in_used_next = in_used_reg + 1'b1;
                    end
                    else
                    begin
                        out_used_next = out_used_reg + 1'b1;
                    end
                end
                else
                begin
                end
            end
            if (evt.trunc)
            begin
                malformed_next = 1'b1;
            end
        end
    end

    // record selection: endpoint first, summary after
    always_comb
    begin
        res = '0;
        if (rec)
        begin
            res.record_type         = REC_ENDPOINT;
            res.interface_slot      = 4'(opened_reg - 1'b1);
            res.direction_in        = is_in;
            res.endpoint_slot       = 2'(used_cur);
            res.endpoint_number     = 4'(evt.address & EP_NUM_MASK);
            res.max_packet_size     = evt.size;
            res.endpoint_attributes = evt.attributes;
            res.last_result         = !evt.last;
        end
        else
        begin
            res.record_type     = REC_SUMMARY;
            res.interface_count = declared_next;
            res.malformed       = malformed_next;
            res.last_result     = 1'b1;
        end
    end

    assign room    = (oq_count_reg != 2'd2) || pop;
    assign fire    = evt_valid && room;
    assign emit    = fire && (rec || evt.last || phase_reg);
    assign deq     = fire && !(rec && evt.last);
    assign evt_pop = deq;

    // tracking state, cleared after the summary
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            declared_reg  <= '0;
            opened_reg    <= '0;
            in_used_reg   <= '0;
            out_used_reg  <= '0;
            inside_reg    <= 1'b0;
            stopped_reg   <= 1'b0;
            malformed_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else if (fire)
        begin
            if (deq && evt.last)
            begin
                declared_reg  <= '0;
                opened_reg    <= '0;
                in_used_reg   <= '0;
                out_used_reg  <= '0;
                inside_reg    <= 1'b0;
                stopped_reg   <= 1'b0;
                malformed_reg <= 1'b0;
                phase_reg     <= 1'b0;
            end
            else
            begin
                declared_reg  <= declared_next;
                opened_reg    <= opened_next;
                in_used_reg   <= in_used_next;
                out_used_reg  <= out_used_next;
                inside_reg    <= inside_next;
                stopped_reg   <= stopped_next;
                malformed_reg <= malformed_next;
                phase_reg     <= !deq;
            end
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            oq[oq_wr_reg] <= res;
        end
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
            oq_count_reg <= 2'd0;
        end
        else
        begin
            if (emit)
            begin
                oq_wr_reg <= !oq_wr_reg;
            end
            if (pop && !empty)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            priority if (emit && !(pop && !empty))
            begin
                oq_count_reg <= oq_count_reg + 2'd1;
            end
            else if (!emit && pop && !empty)
            begin
                oq_count_reg <= oq_count_reg - 2'd1;
            end
        end
    end

    assign empty  = (oq_count_reg == 2'd0);
    assign result = oq[oq_rd_reg];

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the configuration descriptor parser. Byte
// streams go in through the push side. Most are well-formed configuration
// buffers with random content. Others are damaged: cut short, with a zero
// length byte, or random noise. A built-in model of the descriptor
// framing and the interface and endpoint bookkeeping predicts each endpoint
// record and summary. Every popped record is checked against the model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import ucdp_pkg::*;

    localparam int MAX_IF      = 4;
    localparam int EP_PER_DIR  = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 16;
    localparam int PHASE_BYTES = 150;
    localparam int REPORT_MAX  = 10;

    // a class-specific descriptor type the parser must skip
    localparam logic [7:0] KIND_CLASS_HID = 8'h21;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        record_type;
    logic [3:0]  interface_slot;
    logic        direction_in;
    logic [1:0]  endpoint_slot;
    logic [3:0]  endpoint_number;
    logic [15:0] max_packet_size;
    logic [7:0]  endpoint_attributes;
    logic [4:0]  interface_count;
    logic        malformed;
    logic        last_result;

    usb_config_descriptor_endpoint_parser
    #(
        .MAX_INTERFACES          (MAX_IF),
        .ENDPOINTS_PER_DIRECTION (EP_PER_DIR)
    )
    uut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .full                (full),
        .data_byte           (data_byte),
        .last_byte           (last_byte),
        .empty               (empty),
        .pop                 (pop),
        .record_type         (record_type),
        .interface_slot      (interface_slot),
        .direction_in        (direction_in),
        .endpoint_slot       (endpoint_slot),
        .endpoint_number     (endpoint_number),
        .max_packet_size     (max_packet_size),
        .endpoint_attributes (endpoint_attributes),
        .interface_count     (interface_count),
        .malformed           (malformed),
        .last_result         (last_result)
    );

    // clock
    always #2 clk = ~clk;

    // expected records, oldest first
    result_t     expected_records[$];
    logic [7:0]  frame_bytes[$];
    int          desc_starts[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          bytes_sent = 0;
    int          error_count = 0;
    result_t     got_rec;
    result_t     want_rec;

    // parser model state
    logic [7:0]  parse_pos = '0;
    logic [7:0]  desc_len = '0;
    logic [7:0]  desc_kind = '0;
    logic [7:0]  ep_addr = '0;
    logic [7:0]  ep_attr = '0;
    logic [15:0] ep_size = '0;
    logic [4:0]  if_declared = '0;
    logic [4:0]  if_opened = '0;
    logic [2:0]  in_count = '0;
    logic [2:0]  out_count = '0;
    logic        in_iface = 1'b0;
    logic        parse_stopped = 1'b0;
    logic        bad_seen = 1'b0;

    function automatic string fmt_record(input result_t r);
        return {$sformatf("type=%0d if=%0d in=%0d slot=%0d ep=%0d ",
                    r.record_type, r.interface_slot, r.direction_in,
                    r.endpoint_slot, r.endpoint_number),
                $sformatf("mps=%h attr=%h cnt=%0d bad=%0d last=%0d",
                    r.max_packet_size, r.endpoint_attributes,
                    r.interface_count, r.malformed, r.last_result)};
    endfunction

    // act on a descriptor whose final byte just arrived
    task automatic close_descriptor(input logic is_last);
        result_t    rec;
        logic [4:0] owner;
        logic       is_in;
        rec = '0;
        if (desc_kind == KIND_CONFIG)
        begin
            if (ep_size[7:0] > MAX_IF)
                if_declared = 5'(MAX_IF);
            else
                if_declared = ep_size[4:0];
            in_iface = 1'b0;
        end
        else if (desc_kind == KIND_INTERFACE)
        begin
            if (if_opened >= MAX_IF)
            begin
                parse_stopped = 1'b1;
                in_iface = 1'b0;
            end
            else
            begin
                if_opened = if_opened + 5'd1;
                in_iface = 1'b1;
                in_count = '0;
                out_count = '0;
            end
        end
        else if (desc_kind == KIND_ENDPOINT && in_iface)
        begin
            is_in = ep_addr[DIR_IN_BIT];
            if ((is_in ? in_count : out_count) < EP_PER_DIR)
            begin
                owner = if_opened - 5'd1;
                rec.record_type = REC_ENDPOINT;
                rec.interface_slot = owner[3:0];
                rec.direction_in = is_in;
                rec.endpoint_slot = is_in ? in_count[1:0] : out_count[1:0];
                rec.endpoint_number = ep_addr[3:0] & EP_NUM_MASK[3:0];
                rec.max_packet_size = ep_size;
                rec.endpoint_attributes = ep_attr;
                rec.last_result = !is_last;
                expected_records.push_back(rec);
                if (is_in)
                    in_count = in_count + 3'd1;
                else
                    out_count = out_count + 3'd1;
            end
        end
    endtask

    // model one accepted byte
    task automatic predict_byte(input logic [7:0] d, input logic is_last);
        result_t    rec;
        logic [7:0] off;
        off = parse_pos;
        if (!parse_stopped)
        begin
            case (off)
                8'd0:
                begin
                    if (d == 8'h00)
                    begin
                        parse_stopped = 1'b1;
                        bad_seen = 1'b1;
                    end
                    else
                    begin
                        desc_len = d;
                        desc_kind = '0;
                        ep_addr = '0;
                        ep_attr = '0;
                        ep_size = '0;
                    end
                end
                8'd1: desc_kind = d;
                8'd2: ep_addr = d;
                8'd3: ep_attr = d;
                8'd4: ep_size[7:0] = d;
                8'd5: ep_size[15:8] = d;
                default: ;
            endcase
            if (!parse_stopped)
            begin
                if (int'(off) + 1 >= int'(desc_len))
                begin
                    parse_pos = '0;
                    close_descriptor(is_last);
                end
                else
                    parse_pos = off + 8'd1;
            end
        end
        // end of buffer: summary, then back to the idle parse state
        if (is_last)
        begin
            if (!parse_stopped && parse_pos != 0)
                bad_seen = 1'b1;
            rec = '0;
            rec.record_type = REC_SUMMARY;
            rec.interface_count = if_declared;
            rec.malformed = bad_seen;
            rec.last_result = 1'b1;
            expected_records.push_back(rec);
            parse_pos = '0;
            desc_len = '0;
            desc_kind = '0;
            ep_addr = '0;
            ep_attr = '0;
            ep_size = '0;
            if_declared = '0;
            if_opened = '0;
            in_count = '0;
            out_count = '0;
            in_iface = 1'b0;
            parse_stopped = 1'b0;
            bad_seen = 1'b0;
        end
    endtask

    // one byte transaction, with an optional idle gap afterwards
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        data_byte <= value;
        last_byte <= is_last;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_byte(value, is_last);
        bytes_sent++;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // hold the sender off until every expected record has been popped
    task automatic wait_drained();
        push <= 1'b0;
        do
            @(posedge clk);
        while (expected_records.size() != 0);
    endtask

    // fields past offset 5 are filler
    task automatic add_descriptor(input int len, input logic [7:0] kind,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [7:0] b4, input logic [7:0] b5);
        desc_starts.push_back(frame_bytes.size());
        frame_bytes.push_back(len[7:0]);
        for (int i = 1; i < len; i++)
        begin
            case (i)
                1: frame_bytes.push_back(kind);
                2: frame_bytes.push_back(b2);
                3: frame_bytes.push_back(b3);
                4: frame_bytes.push_back(b4);
                5: frame_bytes.push_back(b5);
                default: frame_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic add_endpoint();
        int         len;
        int         pick;
        logic [15:0] mps;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            len = 7;
        else if (pick < 92)
            len = 9;
        else
            len = $urandom_range(1, 6);
        if ($urandom_range(0, 1))
            mps = 16'($urandom_range(0, 1024));
        else
            mps = 16'($urandom_range(0, 65535));
        add_descriptor(len, KIND_ENDPOINT, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), mps[7:0], mps[15:8]);
    endtask

    // mostly well-formed buffers; some cut short, zeroed or pure noise
    task automatic build_random_frame();
        int n_if;
        int n_ep;
        int cut;
        int k;
        frame_bytes.delete();
        desc_starts.delete();
        if ($urandom_range(0, 99) < 8)
        begin
            repeat ($urandom_range(1, 40))
                frame_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        add_descriptor(9, KIND_CONFIG, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)),
                       8'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 6)
                                                       : $urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 15)
            add_endpoint();
        n_if = $urandom_range(0, 6);
        for (int i = 0; i < n_if; i++)
        begin
            if ($urandom_range(0, 99) < 20)
                add_descriptor(9, KIND_CLASS_HID, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
            add_descriptor(9, KIND_INTERFACE, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 5)
                add_descriptor(9, KIND_CONFIG, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 8)),
                               8'($urandom_range(0, 255)));
            n_ep = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 9) : $urandom_range(0, 4);
            repeat (n_ep)
                add_endpoint();
        end
        if ($urandom_range(0, 99) < 6)
        begin
            k = $urandom_range(0, desc_starts.size() - 1);
            frame_bytes[desc_starts[k]] = 8'h00;
        end
        if ($urandom_range(0, 99) < 12)
        begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
            frame_bytes = frame_bytes[0:cut - 1];
        end
    endtask

    // zero length byte stops parsing; later bytes are ignored
    task automatic test_zero_length();
        frame_bytes = {8'h00, 8'hFF};
        send_frame();
    endtask

    // one-byte descriptor has no type and is skipped
    task automatic test_one_byte_descriptor();
        frame_bytes = {8'h01};
        send_frame();
    endtask

    // buffer ends inside a descriptor
    task automatic test_truncated();
        frame_bytes = {8'h09, KIND_CONFIG};
        send_frame();
    endtask

    // endpoint with no interface open gives no record
    task automatic test_endpoint_outside_interface();
        frame_bytes = {8'h02, KIND_ENDPOINT};
        send_frame();
    endtask

    // short endpoint completed by the last byte: record, then summary
    task automatic test_endpoint_on_last_byte();
        frame_bytes = {8'h02, KIND_INTERFACE, 8'h06, KIND_ENDPOINT,
                       8'h8F, 8'hFF, 8'hFF, 8'hFF};
        send_frame();
    endtask

    // clamped interface count; config closes the open interface
    task automatic test_config_clamp_inside_interface();
        frame_bytes = {8'h02, KIND_INTERFACE, 8'h05, KIND_CONFIG, 8'h00, 8'h00,
                       8'hFF, 8'h02, KIND_ENDPOINT};
        send_frame();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int start;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES)
        begin
            build_random_frame();
            send_frame();
        end
    endtask

    // sender pauses after each buffer until the result side has caught up
    task automatic test_drain_pauses();
        repeat (4)
        begin
            build_random_frame();
            send_frame();
            wait_drained();
        end
    endtask

    // result checker and pop driver
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            got_rec = {record_type, interface_slot, direction_in, endpoint_slot,
                       endpoint_number, max_packet_size, endpoint_attributes,
                       interface_count, malformed, last_result};
            if (expected_records.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected record at %0t: %s", $time, fmt_record(got_rec));
            end
            else
            begin
                want_rec = expected_records.pop_front();
                if (got_rec.record_type != want_rec.record_type
                    || got_rec.interface_slot != want_rec.interface_slot
                    || got_rec.direction_in != want_rec.direction_in
                    || got_rec.endpoint_slot != want_rec.endpoint_slot
                    || got_rec.endpoint_number != want_rec.endpoint_number
                    || got_rec.max_packet_size != want_rec.max_packet_size
                    || got_rec.endpoint_attributes != want_rec.endpoint_attributes
                    || got_rec.interface_count != want_rec.interface_count
                    || got_rec.malformed != want_rec.malformed
                    || got_rec.last_result != want_rec.last_result)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                    begin
                        $display("mismatch at %0t", $time);
                        $display("  expected %s", fmt_record(want_rec));
                        $display("  actual   %s", fmt_record(got_rec));
                    end
                end
            end
        end
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_length();
        test_one_byte_descriptor();
        test_truncated();
        test_endpoint_outside_interface();
        test_endpoint_on_last_byte();
        test_config_clamp_inside_interface();

        test_random_traffic(0, 0);
        test_random_traffic(46, 0);
        test_random_traffic(0, 46);
        test_random_traffic(33, 33);
        test_drain_pauses();

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
